[rtl/core/qes_pkg.sv]
// qes_pkg: shared types and constants for the quantization error statistics block.
// Used by qes_divsqrt and quant_error_stats_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package qes_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_PAIRS_DEF   = 65536;
  localparam int CNT_LIMIT       = 131071;

  localparam int ACC_W  = 48;
  localparam int ABS_W  = 32;
  localparam int CNT_W  = 17;
  localparam int LIM_W  = 24;
  localparam int IDX_W  = 8;
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int NUM_W  = 64;
  localparam int DEN_W  = 32;
  localparam int LOG_W  = 22;

  localparam logic [MUL_W-1:0] TEN_LOG10_2_Q16 = MUL_W'(197283);

  localparam logic [IDX_W-1:0] REG_EXCELLENT  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_GOOD       = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_ACCEPTABLE = IDX_W'(2);

  localparam logic [1:0] GRADE_EXCELLENT  = 2'd0;
  localparam logic [1:0] GRADE_GOOD       = 2'd1;
  localparam logic [1:0] GRADE_ACCEPTABLE = 2'd2;
  localparam logic [1:0] GRADE_POOR       = 2'd3;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } unit_op_t;

  typedef struct packed {
    logic             start;
    unit_op_t         op;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } unit_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] result;
  } unit_resp_t;

endpackage
`default_nettype wire

[rtl/core/qes_divsqrt.sv]
// qes_divsqrt: shared bit-serial unit, restoring divide (64 steps) or integer root (32 steps).
// Depends on qes_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qes_divsqrt (
  input  wire                 clk,
  input  wire                 rst_n,
  input  qes_pkg::unit_req_t  req,
  output qes_pkg::unit_resp_t resp
);
  import qes_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  unit_op_t         op_r, op_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] res_r, res_nxt;
  logic [NUM_W-1:0] bit_r, bit_nxt;

  logic [DEN_W:0]   rem_sh;
  logic [NUM_W-1:0] trial;
  logic             last_step;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    rem_sh   = {rem_r, num_r[NUM_W-1]};
    trial    = res_r + bit_r;
    last_step = (op_r == OP_SQRT) ? (cnt_r == 6'd31) : (cnt_r == 6'd63);
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      cnt_nxt  = '0;
      num_nxt  = req.num;
      den_nxt  = req.den;
      rem_nxt  = '0;
      res_nxt  = '0;
      bit_nxt  = NUM_W'(1) << 62;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 6'd1;
      if (op_r == OP_SQRT) begin
        if (num_r >= trial) begin
          num_nxt = num_r - trial;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
      end else begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = DEN_W'(rem_sh - {1'b0, den_r});
          num_nxt = {num_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[DEN_W-1:0];
          num_nxt = {num_r[NUM_W-2:0], 1'b0};
        end
      end
      if (last_step) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= OP_DIV;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign resp.done   = done_r;
  assign resp.result = (op_r == OP_SQRT) ? res_r : num_r;

endmodule
`default_nettype wire

[rtl/core/quant_error_stats_top.sv]
// quant_error_stats_top: run accumulators, result sequencer, shared multiplier and log steps.
// Depends on qes_pkg and qes_divsqrt.
// A pair that is skipped or past the cap needs only ST_IDLE; a valid pair passes ST_MUL_E,
// ST_MUL_R and ST_ACC on the one shared multiplier (error square, then reference square). When
// no pair was valid the last pair goes through ST_FIN alone; else it runs three or four 64-step
// divides and two 32-step roots on qes_divsqrt, then, when both powers are nonzero, two
// leading-one searches and two 16-squaring log loops. A result held by out_stall keeps the
// input stalled.
// Reset (rst_n low, synchronous): accumulators and counts clear, limits return to 655/3277/6554.
`timescale 1ns / 1ps
`default_nettype none
module quant_error_stats_top #(
  parameter int SAMPLE_BITS = qes_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_PAIRS   = qes_pkg::MAX_PAIRS_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // input channel
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire signed [SAMPLE_BITS-1:0]   in_ref_sample,
  input  wire signed [SAMPLE_BITS-1:0]   in_test_sample,
  input  wire                            in_ref_ok,
  input  wire                            in_test_ok,
  input  wire                            in_last_pair,
  // result channel
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [39:0]                    out_mean_sq_error,
  output logic [23:0]                    out_mean_abs_error,
  output logic [23:0]                    out_rms_error,
  output logic [15:0]                    out_peak_error,
  output logic [23:0]                    out_ref_rms,
  output logic [23:0]                    out_rel_error,
  output logic signed [15:0]             out_sqnr_db,
  output logic [16:0]                    out_valid_count,
  output logic [16:0]                    out_total_count,
  output logic [1:0]                     out_grade,
  // configuration write channel
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [qes_pkg::IDX_W-1:0]       cfg_index,
  input  wire [qes_pkg::LIM_W-1:0]       cfg_data
);
  import qes_pkg::*;

  // Counting stops at this many pairs in a run; a last flag still reports.
  localparam int PAIR_CAP = (MAX_PAIRS < CNT_LIMIT) ? MAX_PAIRS : CNT_LIMIT;

  typedef enum logic [15:0] {
    ST_IDLE    = 16'b0000_0000_0000_0001,
    ST_MUL_E   = 16'b0000_0000_0000_0010,
    ST_MUL_R   = 16'b0000_0000_0000_0100,
    ST_ACC     = 16'b0000_0000_0000_1000,
    ST_FIN     = 16'b0000_0000_0001_0000,
    ST_DIV_MSE = 16'b0000_0000_0010_0000,
    ST_DIV_MAE = 16'b0000_0000_0100_0000,
    ST_DIV_PW  = 16'b0000_0000_1000_0000,
    ST_SQ_RMS  = 16'b0000_0001_0000_0000,
    ST_SQ_RRMS = 16'b0000_0010_0000_0000,
    ST_DIV_REL = 16'b0000_0100_0000_0000,
    ST_NORM    = 16'b0000_1000_0000_0000,
    ST_LOG_MUL = 16'b0001_0000_0000_0000,
    ST_LOG_UPD = 16'b0010_0000_0000_0000,
    ST_DB_MUL  = 16'b0100_0000_0000_0000,
    ST_DB_RND  = 16'b1000_0000_0000_0000
  } state_t;

  // Finished results wait in ST_IDLE under fin_r until the output register takes them.
  state_t state_r, state_nxt;

  logic [LIM_W-1:0] exc_r, good_r, acc_lim_r;
  logic [ACC_W-1:0] sum_sq_r, sum_sq_nxt;
  logic [ACC_W-1:0] sum_ref_r, sum_ref_nxt;
  logic [ABS_W-1:0] sum_abs_r, sum_abs_nxt;
  logic [15:0]      max_r, max_nxt;
  logic [CNT_W-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0] all_r, all_nxt;
  logic             last_r, last_nxt;
  logic             run_r, run_nxt;
  logic             fin_r, fin_nxt;     // results complete, waiting for the output register
  logic             log_sel_r, log_sel_nxt;

  logic [MUL_W-1:0] e_r, e_nxt;
  logic [MUL_W-1:0] ra_r, ra_nxt;
  logic [PROD_W-1:0] mul_p_r;
  logic [MUL_W-1:0] mul_a, mul_b;

  logic [55:0]      mse_r, mse_nxt;
  logic [39:0]      mae_r, mae_nxt;
  logic [55:0]      pw_r, pw_nxt;
  logic [31:0]      rms_r, rms_nxt;
  logic [31:0]      rrms_r, rrms_nxt;
  logic [23:0]      rel_r, rel_nxt;
  logic [15:0]      sq_r, sq_nxt;
  logic [ACC_W-1:0] x_r, x_nxt;
  logic [5:0]       p_r, p_nxt;
  logic [31:0]      m_r, m_nxt;
  logic [15:0]      frac_r, frac_nxt;
  logic [3:0]       it_r, it_nxt;
  logic [LOG_W-1:0] la_r, la_nxt;
  logic [LOG_W-1:0] lb_r, lb_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [39:0]      o_mse_r;
  logic [23:0]      o_mae_r, o_rms_r, o_rrms_r, o_rel_r;
  logic [15:0]      o_peak_r, o_sq_r;
  logic [CNT_W-1:0] o_vc_r, o_tc_r;
  logic [1:0]       o_grade_r;
  logic             out_load;

  unit_req_t        ureq;
  unit_resp_t       uresp;

  logic             in_xfer;
  logic             counting;
  logic signed [MUL_W:0] r_x, t_x, d_x;
  logic [ACC_W:0]   sq_sum, ref_sum;
  logic             prod_big;           // product alone exceeds the accumulator width
  logic [ABS_W:0]   abs_sum;
  logic [15:0]      e_sat;
  logic [MUL_W-1:0] t_log;
  logic             neg;
  logic [LOG_W-1:0] mag;
  logic [PROD_W:0]  rnd;
  logic [PROD_W-24:0] q;
  logic [1:0]       grade;

  qes_divsqrt u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ureq),
    .resp  (uresp)
  );

  assign in_stall  = (state_r != ST_IDLE) || fin_r;
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign counting  = (all_r < CNT_W'(PAIR_CAP));

  // Shared multiplier, registered output.
  always_comb begin
    mul_a = e_r;
    mul_b = e_r;
    unique case (state_r)
      ST_MUL_R: begin
        mul_a = ra_r;
        mul_b = ra_r;
      end
      ST_LOG_MUL: begin
        mul_a = MUL_W'(m_r);
        mul_b = MUL_W'(m_r);
      end
      ST_DB_MUL: begin
        mul_a = MUL_W'(mag);
        mul_b = TEN_LOG10_2_Q16;
      end
      default: begin
        mul_a = e_r;
        mul_b = e_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  // Grade and sqnr helpers.
  always_comb begin
    if (rel_r < exc_r)          grade = GRADE_EXCELLENT;
    else if (rel_r < good_r)    grade = GRADE_GOOD;
    else if (rel_r < acc_lim_r) grade = GRADE_ACCEPTABLE;
    else                        grade = GRADE_POOR;
    neg   = lb_r > la_r;
    mag   = neg ? (lb_r - la_r) : (la_r - lb_r);
    rnd   = {1'b0, mul_p_r} + (PROD_W+1)'(24'h80_0000);
    q     = rnd[PROD_W:24];
    t_log = mul_p_r[63:31];
  end

  assign out_load = fin_r && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt   = state_r;
    sum_sq_nxt  = sum_sq_r;
    sum_ref_nxt = sum_ref_r;
    sum_abs_nxt = sum_abs_r;
    max_nxt     = max_r;
    valid_nxt   = valid_r;
    all_nxt     = all_r;
    last_nxt    = last_r;
    run_nxt     = run_r;
    fin_nxt     = fin_r;
    log_sel_nxt = log_sel_r;
    e_nxt       = e_r;
    ra_nxt      = ra_r;
    mse_nxt     = mse_r;
    mae_nxt     = mae_r;
    pw_nxt      = pw_r;
    rms_nxt     = rms_r;
    rrms_nxt    = rrms_r;
    rel_nxt     = rel_r;
    sq_nxt      = sq_r;
    x_nxt       = x_r;
    p_nxt       = p_r;
    m_nxt       = m_r;
    frac_nxt    = frac_r;
    it_nxt      = it_r;
    la_nxt      = la_r;
    lb_nxt      = lb_r;
    ureq.start  = 1'b0;
    ureq.op     = OP_DIV;
    ureq.num    = '0;
    ureq.den    = DEN_W'(valid_r);

    r_x      = (MUL_W+1)'(in_ref_sample);
    t_x      = (MUL_W+1)'(in_test_sample);
    d_x      = r_x - t_x;
    prod_big = |mul_p_r[PROD_W-1:ACC_W];
    sq_sum   = (ACC_W+1)'(sum_sq_r) + (ACC_W+1)'(mul_p_r[ACC_W-1:0]);
    ref_sum  = (ACC_W+1)'(sum_ref_r) + (ACC_W+1)'(mul_p_r[ACC_W-1:0]);
    abs_sum  = (ABS_W+1)'(sum_abs_r) + (ABS_W+1)'(e_r);
    e_sat    = (|e_r[MUL_W-1:16]) ? 16'hFFFF : e_r[15:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          last_nxt = in_last_pair;
          e_nxt    = d_x[MUL_W] ? MUL_W'(-d_x) : d_x[MUL_W-1:0];
          ra_nxt   = r_x[MUL_W] ? MUL_W'(-r_x) : r_x[MUL_W-1:0];
          if (counting) begin
            all_nxt = all_r + CNT_W'(1);
          end
          if (counting && in_ref_ok && in_test_ok) begin
            valid_nxt = valid_r + CNT_W'(1);
            state_nxt = ST_MUL_E;
          end else if (in_last_pair) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_MUL_E: begin
        abs_sum     = (ABS_W+1)'(sum_abs_r) + (ABS_W+1)'(e_r);
        sum_abs_nxt = abs_sum[ABS_W] ? '1 : abs_sum[ABS_W-1:0];
        if (e_sat > max_r) max_nxt = e_sat;
        state_nxt = ST_MUL_R;
      end
      ST_MUL_R: begin
        // error square is in the product register
        sum_sq_nxt = (sq_sum[ACC_W] || prod_big) ? '1 : sq_sum[ACC_W-1:0];
        state_nxt  = ST_ACC;
      end
      ST_ACC: begin
        sum_ref_nxt = (ref_sum[ACC_W] || prod_big) ? '1 : ref_sum[ACC_W-1:0];
        state_nxt   = last_r ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        rel_nxt = '0;
        sq_nxt  = '0;
        if (valid_r == '0) begin
          mse_nxt   = '0;
          mae_nxt   = '0;
          rms_nxt   = '0;
          rrms_nxt  = '0;
          fin_nxt   = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_DIV_MSE;
        end
      end
      ST_DIV_MSE: begin
        ureq.op  = OP_DIV;
        ureq.num = NUM_W'({sum_sq_r, 8'd0});
        if (!run_r) begin
          ureq.start = 1'b1;
          run_nxt    = 1'b1;
        end else if (uresp.done) begin
          mse_nxt   = uresp.result[55:0];
          run_nxt   = 1'b0;
          state_nxt = ST_DIV_MAE;
        end
      end
      ST_DIV_MAE: begin
        ureq.op  = OP_DIV;
        ureq.num = NUM_W'({sum_abs_r, 8'd0});
        if (!run_r) begin
          ureq.start = 1'b1;
          run_nxt    = 1'b1;
        end else if (uresp.done) begin
          mae_nxt   = uresp.result[39:0];
          run_nxt   = 1'b0;
          state_nxt = ST_DIV_PW;
        end
      end
      ST_DIV_PW: begin
        ureq.op  = OP_DIV;
        ureq.num = NUM_W'({sum_ref_r, 8'd0});
        if (!run_r) begin
          ureq.start = 1'b1;
          run_nxt    = 1'b1;
        end else if (uresp.done) begin
          pw_nxt    = uresp.result[55:0];
          run_nxt   = 1'b0;
          state_nxt = ST_SQ_RMS;
        end
      end
      ST_SQ_RMS: begin
        ureq.op  = OP_SQRT;
        ureq.num = {mse_r, 8'd0};
        if (!run_r) begin
          ureq.start = 1'b1;
          run_nxt    = 1'b1;
        end else if (uresp.done) begin
          rms_nxt   = uresp.result[31:0];
          run_nxt   = 1'b0;
          state_nxt = ST_SQ_RRMS;
        end
      end
      ST_SQ_RRMS: begin
        ureq.op  = OP_SQRT;
        ureq.num = {pw_r, 8'd0};
        if (!run_r) begin
          ureq.start = 1'b1;
          run_nxt    = 1'b1;
        end else if (uresp.done) begin
          rrms_nxt  = uresp.result[31:0];
          run_nxt   = 1'b0;
          state_nxt = ST_DIV_REL;
        end
      end
      ST_DIV_REL: begin
        ureq.op  = OP_DIV;
        ureq.num = NUM_W'({rms_r, 16'd0});
        ureq.den = rrms_r;
        if (sum_ref_r == '0 || rrms_r == '0 || run_r && uresp.done) begin
          if (sum_ref_r != '0 && rrms_r == '0) begin
            rel_nxt = (rms_r != '0) ? '1 : '0;
          end else if (sum_ref_r != '0) begin
            rel_nxt = (|uresp.result[63:24]) ? '1 : uresp.result[23:0];
          end
          run_nxt = 1'b0;
          if (sum_ref_r != '0 && sum_sq_r != '0) begin
            x_nxt       = sum_ref_r;
            p_nxt       = 6'd47;
            log_sel_nxt = 1'b0;
            state_nxt   = ST_NORM;
          end else begin
            fin_nxt   = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (!run_r) begin
          ureq.start = 1'b1;
          run_nxt    = 1'b1;
        end
      end
      ST_NORM: begin
        // leading-one search, one bit a cycle
        if (x_r[ACC_W-1]) begin
          m_nxt     = x_r[ACC_W-1:16];
          frac_nxt  = '0;
          it_nxt    = '0;
          state_nxt = ST_LOG_MUL;
        end else begin
          x_nxt = {x_r[ACC_W-2:0], 1'b0};
          p_nxt = p_r - 6'd1;
        end
      end
      ST_LOG_MUL: begin
        state_nxt = ST_LOG_UPD;
      end
      ST_LOG_UPD: begin
        if (t_log[32]) begin
          m_nxt    = t_log[32:1];
          frac_nxt = {frac_r[14:0], 1'b1};
        end else begin
          m_nxt    = t_log[31:0];
          frac_nxt = {frac_r[14:0], 1'b0};
        end
        it_nxt = it_r + 4'd1;
        if (it_r == 4'd15) begin
          if (!log_sel_r) begin
            la_nxt      = {p_r, frac_nxt};
            x_nxt       = sum_sq_r;
            p_nxt       = 6'd47;
            log_sel_nxt = 1'b1;
            state_nxt   = ST_NORM;
          end else begin
            lb_nxt    = {p_r, frac_nxt};
            state_nxt = ST_DB_MUL;
          end
        end else begin
          state_nxt = ST_LOG_MUL;
        end
      end
      ST_DB_MUL: begin
        state_nxt = ST_DB_RND;
      end
      ST_DB_RND: begin
        if (neg) begin
          sq_nxt = (q > (PROD_W-23)'(32768)) ? 16'h8000 : 16'(~q + 1'b1);
        end else begin
          sq_nxt = (q > (PROD_W-23)'(32767)) ? 16'h7FFF : q[15:0];
        end
        fin_nxt   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      fin_nxt     = 1'b0;
      sum_sq_nxt  = '0;
      sum_ref_nxt = '0;
      sum_abs_nxt = '0;
      max_nxt     = '0;
      valid_nxt   = '0;
      all_nxt     = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  // Control, accumulators and limits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      exc_r       <= LIM_W'(655);
      good_r      <= LIM_W'(3277);
      acc_lim_r   <= LIM_W'(6554);
      sum_sq_r    <= '0;
      sum_ref_r   <= '0;
      sum_abs_r   <= '0;
      max_r       <= '0;
      valid_r     <= '0;
      all_r       <= '0;
      last_r      <= 1'b0;
      run_r       <= 1'b0;
      fin_r       <= 1'b0;
      log_sel_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_sq_r    <= sum_sq_nxt;
      sum_ref_r   <= sum_ref_nxt;
      sum_abs_r   <= sum_abs_nxt;
      max_r       <= max_nxt;
      valid_r     <= valid_nxt;
      all_r       <= all_nxt;
      last_r      <= last_nxt;
      run_r       <= run_nxt;
      fin_r       <= fin_nxt;
      log_sel_r   <= log_sel_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_EXCELLENT:  exc_r     <= cfg_data;
          REG_GOOD:       good_r    <= cfg_data;
          REG_ACCEPTABLE: acc_lim_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk) begin
    e_r    <= e_nxt;
    ra_r   <= ra_nxt;
    mse_r  <= mse_nxt;
    mae_r  <= mae_nxt;
    pw_r   <= pw_nxt;
    rms_r  <= rms_nxt;
    rrms_r <= rrms_nxt;
    rel_r  <= rel_nxt;
    sq_r   <= sq_nxt;
    x_r    <= x_nxt;
    p_r    <= p_nxt;
    m_r    <= m_nxt;
    frac_r <= frac_nxt;
    it_r   <= it_nxt;
    la_r   <= la_nxt;
    lb_r   <= lb_nxt;
    if (out_load) begin
      o_mse_r   <= (|mse_r[55:40]) ? '1 : mse_r[39:0];
      o_mae_r   <= (|mae_r[39:24]) ? '1 : mae_r[23:0];
      o_rms_r   <= (|rms_r[31:24]) ? '1 : rms_r[23:0];
      o_rrms_r  <= (|rrms_r[31:24]) ? '1 : rrms_r[23:0];
      o_rel_r   <= rel_r;
      o_sq_r    <= sq_r;
      o_peak_r  <= (valid_r != '0) ? max_r : '0;
      o_vc_r    <= valid_r;
      o_tc_r    <= all_r;
      o_grade_r <= grade;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mean_sq_error  = o_mse_r;
  assign out_mean_abs_error = o_mae_r;
  assign out_rms_error      = o_rms_r;
  assign out_peak_error     = o_peak_r;
  assign out_ref_rms        = o_rrms_r;
  assign out_rel_error      = o_rel_r;
  assign out_sqnr_db        = o_sq_r;
  assign out_valid_count    = o_vc_r;
  assign out_total_count    = o_tc_r;
  assign out_grade          = o_grade_r;

endmodule
`default_nettype wire
